// File: rtl/core/hkvt_pkg.sv
// Package: constants, codes and types shared by the hash key-value table.
`timescale 1ns / 1ps
package hkvt_pkg;
  localparam int BucketsDefault = 256;
  localparam int EntriesDefault = 128;
  localparam logic [31:0] HashBasis = 32'h811c9dc5;
  localparam logic [31:0] HashPrime = 32'h01000193;

  typedef enum logic [1:0] {
    CMD_PUT = 2'd0, CMD_PUT_NEW = 2'd1, CMD_GET = 2'd2, CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_PRESENT = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_WAIT, S_ENT_RD, S_ENT_WAIT, S_COMPARE,
    S_FREE_SCAN, S_ACT, S_OUT
  } state_t;
endpackage

// File: rtl/core/hkvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module hkvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/hash_key_value_table_core.sv
// Top level: chained hash key-value table over RAM-based bucket and entry stores.
// Sequence: the key is hashed a byte at a time, the bucket head is read, each chain entry visited
// is read and compared, a walk that misses ends, an insert of a new key then scans past in-use
// slots for a free one, and the stores are updated as the response is registered.
// Throughput: one item at a time; in_ready returns once the response beat has been taken.
// Reset: bucket heads are cleared by a pass over every bucket (no item accepted);
// in-use bits and the entry count reset at once.
`timescale 1ns / 1ps
module hash_key_value_table_core
  import hkvt_pkg::*;
#(
  parameter int BUCKETS = BucketsDefault,
  parameter int ENTRIES = EntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic [63:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] value_out,
  output logic        old_valid
);
  localparam int BW = $clog2(BUCKETS);
  localparam int EW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Head word: valid bit plus slot. Link word likewise.
  localparam int HW = EW + 1;

  state_t state, state_next;

  // Request registers
  cmd_t        r_cmd;
  logic [63:0] r_key, r_val;
  logic [31:0] hash;
  logic [2:0]  hstep;
  logic [BW-1:0] bkt;

  // Walk registers
  logic          cur_ok;
  logic [EW-1:0] cur, prev, slot;
  logic          has_prev, found;
  logic [CW-1:0] steps;
  logic [63:0]   old_val;
  logic          nxt_ok;
  logic [EW-1:0] nxt;
  logic          head_ok;
  logic [EW-1:0] head;
  logic          walk_ok;

  // Pool bookkeeping
  logic [ENTRIES-1:0] in_use;
  logic [CW-1:0]      count;
  logic [EW-1:0]      free_idx;

  // Clear pass
  logic          clearing;
  logic [BW:0]   clr_idx;

  // Result register
  logic        o_valid;
  logic [1:0]  o_status;
  logic [63:0] o_value;
  logic        o_old;

  // RAM ports
  logic          h_we;
  logic [BW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic          k_we, v_we, l_we;
  logic [EW-1:0] k_waddr, v_waddr, l_waddr, e_raddr;
  logic [63:0]   k_wdata, v_wdata, k_rdata, v_rdata;
  logic [HW-1:0] l_wdata, l_rdata;

  hkvt_ram #(.Width(HW), .Depth(BUCKETS)) u_heads (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));
  hkvt_ram #(.Width(64), .Depth(ENTRIES)) u_keys (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(e_raddr), .rdata(k_rdata));
  hkvt_ram #(.Width(64), .Depth(ENTRIES)) u_vals (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(e_raddr), .rdata(v_rdata));
  hkvt_ram #(.Width(HW), .Depth(ENTRIES)) u_links (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(e_raddr), .rdata(l_rdata));

  assign in_ready  = (state == S_IDLE) && !clearing;
  assign out_valid = o_valid;
  assign status    = o_status;
  assign value_out = o_value;
  assign old_valid = o_old;

  logic ins_cmd;
  assign ins_cmd = (r_cmd == CMD_PUT) || (r_cmd == CMD_PUT_NEW);

  // First visit takes the link straight from the head read
  assign walk_ok = (steps == '0) ? h_rdata[EW] : cur_ok;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid && in_ready) state_next = S_HASH;
      S_HASH:      if (hstep == 3'd7) state_next = S_HEAD_RD;
      S_HEAD_RD:   state_next = S_HEAD_WAIT;
      S_HEAD_WAIT: state_next = S_ENT_RD;
      S_ENT_RD: begin
        if (walk_ok && steps < CW'(ENTRIES)) state_next = S_ENT_WAIT;
        else if (ins_cmd && count < CW'(ENTRIES)) state_next = S_FREE_SCAN;
        else state_next = S_ACT;
      end
      S_ENT_WAIT:  state_next = S_COMPARE;
      S_COMPARE: begin
        if (k_rdata == r_key) state_next = S_ACT;
        else state_next = S_ENT_RD;
      end
      S_FREE_SCAN: if (!in_use[free_idx]) state_next = S_ACT;
      S_ACT:       state_next = S_OUT;
      S_OUT:       if (!o_valid) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory port control
  always_comb begin
    h_we = 1'b0; h_waddr = bkt; h_wdata = '0; h_raddr = bkt;
    k_we = 1'b0; k_waddr = free_idx; k_wdata = r_key;
    v_we = 1'b0; v_waddr = free_idx; v_wdata = r_val;
    l_we = 1'b0; l_waddr = free_idx; l_wdata = {head_ok, head};
    e_raddr = cur;
    if (clearing) begin
      h_we = 1'b1; h_waddr = clr_idx[BW-1:0];
    end
    if (state == S_ACT) begin
      if (found) begin
        if (r_cmd == CMD_PUT) begin
          v_we = 1'b1; v_waddr = slot;
        end else if (r_cmd == CMD_REMOVE) begin
          if (has_prev) begin
            l_we = 1'b1; l_waddr = prev; l_wdata = {nxt_ok, nxt};
          end else begin
            h_we = 1'b1; h_wdata = {nxt_ok, nxt};
          end
        end
      end else if (ins_cmd && count < CW'(ENTRIES)) begin
        k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
        h_we = 1'b1; h_wdata = {1'b1, free_idx};
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      in_use   <= '0;
      count    <= '0;
      o_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == (BW+1)'(BUCKETS - 1)) clearing <= 1'b0;
      end
      if (o_valid && out_ready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            r_cmd <= cmd_t'(cmd);
            r_key <= key;
            r_val <= value_in;
            hash  <= HashBasis;
            hstep <= '0;
          end
        end
        S_HASH: begin
          // One FNV-1 byte step per cycle
          hash  <= (hash * HashPrime) ^ {24'd0, r_key[8*hstep +: 8]};
          hstep <= hstep + 1'b1;
        end
        S_HEAD_RD: begin
          bkt <= hash[BW-1:0];
        end
        S_HEAD_WAIT: begin
          found    <= 1'b0;
          has_prev <= 1'b0;
          steps    <= '0;
          free_idx <= '0;
        end
        S_ENT_RD: begin
          if (steps == '0) begin
            head_ok <= h_rdata[EW];
            head    <= h_rdata[EW-1:0];
            cur_ok  <= h_rdata[EW];
            cur     <= h_rdata[EW-1:0];
          end
        end
        S_COMPARE: begin
          if (k_rdata == r_key) begin
            found   <= 1'b1;
            slot    <= cur;
            old_val <= v_rdata;
            nxt_ok  <= l_rdata[EW];
            nxt     <= l_rdata[EW-1:0];
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur_ok   <= l_rdata[EW];
            cur      <= l_rdata[EW-1:0];
            steps    <= steps + 1'b1;
          end
        end
        S_FREE_SCAN: begin
          if (in_use[free_idx]) free_idx <= free_idx + 1'b1;
        end
        S_ACT: begin
          o_valid  <= 1'b1;
          o_status <= ST_OK;
          o_value  <= '0;
          o_old    <= 1'b0;
          if (ins_cmd) begin
            if (found) begin
              if (r_cmd == CMD_PUT) begin
                o_value <= old_val; o_old <= 1'b1;
              end else begin
                o_status <= ST_PRESENT;
              end
            end else if (count < CW'(ENTRIES)) begin
              in_use[free_idx] <= 1'b1;
              count <= count + 1'b1;
            end else begin
              o_status <= ST_FULL;
            end
          end else if (!found) begin
            o_status <= ST_NOT_FOUND;
          end else begin
            o_value <= old_val; o_old <= 1'b1;
            if (r_cmd == CMD_REMOVE) begin
              in_use[slot] <= 1'b0;
              count <= count - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (count <= CW'(ENTRIES)) else $error("entry count overflow");
    end
  end
  ap_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("accepted during clear");
  ap_count: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(count)) else $error("count mismatch");
  ap_result: assert property (@(posedge clk) disable iff (rst)
    state == S_ACT |=> o_valid) else $error("result lost");
endmodule

// File: bench/hkvt_checker.sv
// Checker for the hash key-value table: predicts every response and compares it.
`timescale 1ns / 1ps
module hkvt_checker
  import hkvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic [63:0] value_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [63:0] value_out,
  input  logic        old_valid,
  output int          fail_count,
  output int          pending,
  output int          resp_count
);
  localparam int NBUCK = BucketsDefault;
  localparam int NENT = EntriesDefault;

  typedef struct packed {
    status_t     st;
    logic [63:0] val;
    logic        ov;
  } resp_t;

  // shadow table state
  int          head [NBUCK];
  bit          head_ok [NBUCK];
  logic [63:0] slot_key [NENT];
  logic [63:0] slot_val [NENT];
  int          slot_next [NENT];
  bit          next_ok [NENT];
  bit          busy [NENT];
  int          used;
  resp_t       expected_q [$];

  function automatic logic [31:0] fnv1_key(logic [63:0] k);
    logic [31:0] h;
    h = HashBasis;
    for (int i = 0; i < 8; i++) h = (h * HashPrime) ^ {24'd0, k[8*i +: 8]};
    return h;
  endfunction

  function automatic resp_t table_apply(cmd_t c, logic [63:0] k, logic [63:0] v);
    resp_t r;
    int b, cur, prev, steps, s;
    bit cok, found, has_prev;
    r = '{ST_OK, 64'd0, 1'b0};
    b = fnv1_key(k) % NBUCK;
    cok = head_ok[b]; cur = head[b]; steps = 0; found = 0; has_prev = 0; prev = 0;
    while (cok && steps < NENT && !found) begin
      if (slot_key[cur] == k) found = 1;
      else begin
        prev = cur; has_prev = 1; cok = next_ok[cur]; cur = slot_next[cur]; steps++;
      end
    end
    if (c == CMD_PUT || c == CMD_PUT_NEW) begin
      if (found) begin
        if (c == CMD_PUT) begin
          r.val = slot_val[cur]; r.ov = 1; slot_val[cur] = v;
        end else r.st = ST_PRESENT;
      end else if (used >= NENT) r.st = ST_FULL;
      else begin
        s = 0;
        while (busy[s]) s++;
        slot_key[s] = k; slot_val[s] = v; slot_next[s] = head[b];
        next_ok[s] = head_ok[b]; busy[s] = 1; head[b] = s; head_ok[b] = 1; used++;
      end
    end else if (!found) r.st = ST_NOT_FOUND;
    else begin
      r.val = slot_val[cur]; r.ov = 1;
      if (c == CMD_REMOVE) begin
        if (has_prev) begin
          slot_next[prev] = slot_next[cur]; next_ok[prev] = next_ok[cur];
        end else begin
          head[b] = slot_next[cur]; head_ok[b] = next_ok[cur];
        end
        next_ok[cur] = 0; busy[cur] = 0; used--;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      for (int i = 0; i < NBUCK; i++) begin head[i] = 0; head_ok[i] = 0; end
      for (int i = 0; i < NENT; i++) begin busy[i] = 0; next_ok[i] = 0; end
      used = 0;
      expected_q.delete();
      fail_count = 0;
      resp_count = 0;
    end else begin
      // response beat is checked before the request beat of the same edge
      if (out_valid && out_ready) begin
        resp_count++;
        if (expected_q.size() == 0) report_mismatch("response with nothing expected");
        else begin
          e = expected_q.pop_front();
          if (status !== e.st)
            report_mismatch($sformatf("status %0d, want %0d", status, e.st));
          if (value_out !== e.val)
            report_mismatch($sformatf("value_out %h, want %h", value_out, e.val));
          if (old_valid !== e.ov)
            report_mismatch($sformatf("old_valid %b, want %b", old_valid, e.ov));
        end
      end
      if (in_valid && in_ready) expected_q.push_back(table_apply(cmd_t'(cmd), key, value_in));
    end
  end
endmodule

// File: bench/tb_hash_key_value_table_core.sv
// Testbench top: drives requests to the hash key-value table and gives the verdict.
`timescale 1ns / 1ps
module tb_hash_key_value_table_core;
  import hkvt_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int NRAND = 300;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_GET;
  logic [63:0] key = '0;
  logic [63:0] value_in = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [63:0] value_out;
  logic        old_valid;
  int          fail_count, pending, resp_count;
  int          idle_cycles = 0;
  bit          stim_done = 0;
  logic [63:0] key_pool [16];

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  hash_key_value_table_core u_top (.*);

  hkvt_checker u_chk (.*);

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls: random wait before each response beat
  initial begin
    int w;
    @(negedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_request(cmd_t c, logic [63:0] k, logic [63:0] v, bit burst);
    int w;
    w = burst ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1; cmd <= c; key <= k; value_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    cmd_t c;
    logic [63:0] k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: field extremes, every command, each special outcome
    send_request(CMD_GET, 64'd0, 64'd0, 0);                 // get of missing key
    send_request(CMD_REMOVE, '1, 64'd0, 0);                 // remove of missing key
    send_request(CMD_PUT, 64'd0, '1, 0);                    // new key
    send_request(CMD_PUT, '1, 64'd0, 0);
    send_request(CMD_PUT, 64'd0, 64'h5a5a_a5a5_0f0f_f0f0, 0); // replace
    send_request(CMD_PUT_NEW, 64'd0, 64'd1, 0);             // already present
    send_request(CMD_GET, 64'd0, 64'd0, 0);
    send_request(CMD_GET, '1, '1, 0);
    send_request(CMD_REMOVE, 64'd0, 64'd0, 0);
    send_request(CMD_GET, 64'd0, 64'd0, 0);
    send_request(CMD_PUT_NEW, 64'd0, 64'd7, 0);
    // fill the pool to full, then one more insert and a walk over a long chain
    for (int i = 0; i < EntriesDefault; i++)
      send_request(CMD_PUT_NEW, 64'h1000 + i, rand64(), 1);
    send_request(CMD_PUT, 64'hdead_beef_0000_0001, 64'd3, 0);   // full
    send_request(CMD_PUT_NEW, 64'hdead_beef_0000_0002, 64'd3, 0);
    send_request(CMD_PUT, 64'h1005, 64'd9, 0);                  // replace while full
    for (int i = 0; i < EntriesDefault; i += 2)
      send_request(CMD_REMOVE, 64'h1000 + i, 64'd0, 1);
    // random: keys mostly from a small pool so hits, replaces and removes occur
    for (int i = 0; i < 16; i++) key_pool[i] = rand64();
    key_pool[0] = 64'h1001;
    for (int n = 0; n < NRAND; n++) begin
      c = cmd_t'($urandom_range(0, 3));
      k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 15)] : rand64();
      send_request(c, k, rand64(), (n / 40) % 3 == 2);
    end
    in_valid <= 0;
    stim_done = 1;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran directed edge cases, a full-pool fill and %0d random requests;", NRAND);
    $display("%0d responses checked.", resp_count);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/hkvt_pkg.sv
rtl/core/hkvt_ram.sv
rtl/core/hash_key_value_table_core.sv
bench/hkvt_checker.sv
bench/tb_hash_key_value_table_core.sv
